// ===== sv/sph_kda_pkg.sv =====
// Shared types, widths and kernel constants for the SPH kernel density accumulator.
// No dependencies; every other file in the project refers to this package.
package sph_kda_pkg;

	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int COORD_W = 32;
	localparam int DELTA_W = 28;
	localparam int SUM_W = 40;
	localparam int DENS_W = 64;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 40;

	localparam int MUL_A_W = 40;
	localparam int MUL_B_W = 28;
	localparam int PROD_W = MUL_A_W + MUL_B_W;

	localparam logic [16:0] U_ONE = 17'd65536;
	localparam logic [16:0] U_HALF = 17'd32768;
	// cubic spline coefficients, Q.32
	localparam logic [33:0] K1 = 34'd10937044409;
	localparam logic [35:0] K2 = 36'd65622266455;
	localparam logic [34:0] K5 = 35'd21874088818;
	// 4/3 pi split into a 19-bit upper part and a 16-bit lower part
	localparam logic [18:0] KN_HI = 19'd274516;
	localparam logic [15:0] KN_LO = 16'd36363;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	localparam logic [31:0] BOX_LENGTH_RST = 32'hFFFF_FFFF;
	localparam logic [31:0] SMOOTH_LEN_SQ_RST = 32'd65536;
	localparam logic [31:0] INV_SMOOTH_RST = 32'd65536;
	localparam logic [39:0] INV_SMOOTH_CUBED_RST = 40'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_LENGTH       = 4'd0,
		REG_SMOOTH_LEN_SQ    = 4'd1,
		REG_INV_SMOOTH       = 4'd2,
		REG_INV_SMOOTH_CUBED = 4'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [31:0] box_length;
		logic [31:0] smooth_len_sq;
		logic [31:0] inv_smooth;
		logic [39:0] inv_smooth_cubed;
	} cfg_t;

	// one classified neighbour: minimum-image magnitudes per axis
	typedef struct packed {
		logic [DELTA_W-1:0] ax;
		logic [DELTA_W-1:0] ay;
		logic [DELTA_W-1:0] az;
		logic               far;
		logic               first;
		logic               last;
	} item_t;

	typedef struct packed {
		logic room;
		logic avail;
	} q_status_t;

endpackage

// ===== sv/sph_kda_if.sv =====
// Channel interfaces of the SPH kernel density accumulator: input, result and
// configuration write. Depends on sph_kda_pkg for widths.
interface sph_kda_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] center_x;
	logic [31:0] center_y;
	logic [31:0] center_z;
	logic [31:0] neighbor_x;
	logic [31:0] neighbor_y;
	logic [31:0] neighbor_z;
	logic        first_item;
	logic        last_item;

	modport source (output valid, center_x, center_y, center_z, neighbor_x, neighbor_y,
		neighbor_z, first_item, last_item, input ready);
	modport sink (input valid, center_x, center_y, center_z, neighbor_x, neighbor_y,
		neighbor_z, first_item, last_item, output ready);
endinterface

interface sph_kda_out_if;
	logic                                valid;
	logic                                ready;
	logic [sph_kda_pkg::DENS_W-1:0]      density;
	logic [sph_kda_pkg::SUM_W-1:0]       norm_volume;

	modport source (output valid, density, norm_volume, input ready);
	modport sink (input valid, density, norm_volume, output ready);
endinterface

interface sph_kda_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [sph_kda_pkg::CFG_IDX_W-1:0]    index;
	logic [sph_kda_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/sph_kda_front.sv =====
// Front end: accepts input transactions, registers the raw axis differences and
// classifies them (minimum-image wrap, magnitude, far flag) into the queue.
// Depends on sph_kda_pkg and sph_kda_if.
module sph_kda_front (
	input  logic                   clk,
	input  logic                   arst_n,
	sph_kda_in_if.sink             in_ch,
	input  logic [31:0]            box_length,
	input  sph_kda_pkg::q_status_t q_st,
	output logic                   push,
	output sph_kda_pkg::item_t     push_item
);

	localparam int DW = sph_kda_pkg::DELTA_W;

	logic                s1_valid_q;
	logic signed [32:0]  dx_s1, dy_s1, dz_s1;
	logic                first_s1, last_s1;
	logic [DW:0]         wx, wy, wz;

	function automatic logic [DW:0] wrap_axis(input logic signed [32:0] d,
		input logic [31:0] len);
		logic signed [34:0] dx, d2, lx, dw;
		logic [34:0]        mag;
		dx = {{2{d[32]}}, d};
		d2 = dx <<< 1;
		lx = $signed({3'b000, len});
		if (d2 > lx) begin
			dw = dx - lx;
		end else if (d2 < -lx) begin
			dw = dx + lx;
		end else begin
			dw = dx;
		end
		mag = dw[34] ? 35'(-dw) : 35'(dw);
		wrap_axis = {|mag[34:DW], mag[DW-1:0]};
	endfunction

	assign in_ch.ready = !s1_valid_q || q_st.room;
	assign push = s1_valid_q && q_st.room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			s1_valid_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			dx_s1 <= $signed({1'b0, in_ch.neighbor_x}) - $signed({1'b0, in_ch.center_x});
			dy_s1 <= $signed({1'b0, in_ch.neighbor_y}) - $signed({1'b0, in_ch.center_y});
			dz_s1 <= $signed({1'b0, in_ch.neighbor_z}) - $signed({1'b0, in_ch.center_z});
			first_s1 <= in_ch.first_item;
			last_s1 <= in_ch.last_item;
		end
	end

	always_comb begin
		wx = wrap_axis(dx_s1, box_length);
		wy = wrap_axis(dy_s1, box_length);
		wz = wrap_axis(dz_s1, box_length);
		push_item.ax = wx[DW-1:0];
		push_item.ay = wy[DW-1:0];
		push_item.az = wz[DW-1:0];
		push_item.far = wx[DW] | wy[DW] | wz[DW];
		push_item.first = first_s1;
		push_item.last = last_s1;
	end

endmodule

// ===== sv/sph_kda_fifo.sv =====
// Short queue of classified neighbours between the front and back ends.
// Depends on sph_kda_pkg for the item type.
module sph_kda_fifo #(
	parameter int DEPTH = sph_kda_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  sph_kda_pkg::item_t     push_item,
	input  logic                   pop,
	output sph_kda_pkg::item_t     head,
	output sph_kda_pkg::q_status_t q_st
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sph_kda_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0]      wr_q, rd_q;
	logic [CW-1:0]      cnt_q;

	assign q_st.room = cnt_q != CW'(DEPTH);
	assign q_st.avail = cnt_q != '0;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/sph_kda_back.sv =====
// Back end: sequencer over one shared 40x28 multiplier. Squared distance,
// bit-pair square root, kernel polynomial, saturating sum, and the output scaling.
// Depends on sph_kda_pkg and sph_kda_if.
module sph_kda_back #(
	parameter int COORD_FRAC_BITS = sph_kda_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sph_kda_pkg::cfg_t      cfg,
	input  sph_kda_pkg::q_status_t q_st,
	input  sph_kda_pkg::item_t     head,
	output logic                   pop,
	output logic                   emit,
	sph_kda_out_if.source          out_ch
);

	localparam int AW = sph_kda_pkg::MUL_A_W;
	localparam int BW = sph_kda_pkg::MUL_B_W;
	localparam int PW = sph_kda_pkg::PROD_W;
	localparam int DW = sph_kda_pkg::DELTA_W;
	localparam int SW = sph_kda_pkg::SUM_W;
	localparam int R2W = 2 * DW + 2;
	localparam int SQ_STEPS = (32 + COORD_FRAC_BITS + 1) / 2;
	localparam int SQW = 2 * SQ_STEPS;
	localparam int CNTW = $clog2(SQ_STEPS);
	localparam int USH = 2 * COORD_FRAC_BITS - 16;

	typedef enum logic [4:0] {
		S_IDLE, S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_SQRT, S_USC, S_UCL, S_K0,
		S_KA1, S_KA2, S_KA3, S_KB1, S_KB2, S_KB3, S_FIN,
		S_O0, S_O1, S_O2, S_O3, S_O4, S_EMIT
	} state_t;

	state_t            state_q;
	logic [SW-1:0]     sum_q;
	logic              out_valid_q;
	logic [63:0]       density_q;
	logic [SW-1:0]     norm_q;

	logic [DW-1:0]     ax_q, ay_q, az_q;
	logic              last_q;
	logic [AW-1:0]     mul_a;
	logic [BW-1:0]     mul_b;
	logic [PW-1:0]     prod_q;
	logic [R2W-1:0]    r2_q, r2_tot;
	logic              in_range;
	logic [SQW-1:0]    sq_n_q, sq_res_q, sq_bit_q, sq_try;
	logic [CNTW-1:0]   sq_cnt_q;
	logic [PW-1:0]     u_full;
	logic [16:0]       u_clamped, u_q, v_q;
	logic [33:0]       w_term, w;
	logic [SW:0]       sum_add;
	logic [SW-1:0]     sum_next;
	logic [63:0]       hi_q, dens_q, dens_sat;
	logic [64:0]       dens_sum;
	logic [58:0]       vh_q;
	logic [59:0]       vol_sum;
	logic [43:0]       vol_shift;
	logic [SW-1:0]     vol_q, vol_sat;

	assign pop = (state_q == S_IDLE) && q_st.avail;
	assign emit = (state_q == S_EMIT) && (!out_valid_q || out_ch.ready);
	assign out_ch.valid = out_valid_q;
	assign out_ch.density = density_q;
	assign out_ch.norm_volume = norm_q;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQ0: begin mul_a = AW'(ax_q); mul_b = BW'(ax_q); end
			S_SQ1: begin mul_a = AW'(ay_q); mul_b = BW'(ay_q); end
			S_SQ2: begin mul_a = AW'(az_q); mul_b = BW'(az_q); end
			S_USC: begin
				mul_a = AW'(cfg.inv_smooth);
				mul_b = BW'(sq_res_q[SQ_STEPS-1:0]);
			end
			S_K0: begin
				if (u_q < sph_kda_pkg::U_HALF) begin
					mul_a = AW'(u_q);
					mul_b = BW'(u_q);
				end else begin
					mul_a = AW'(v_q);
					mul_b = BW'(v_q);
				end
			end
			S_KA1, S_KB1: begin mul_a = AW'(prod_q[33:0]); mul_b = BW'(v_q); end
			S_KA2: begin mul_a = AW'(sph_kda_pkg::K2); mul_b = BW'(prod_q[45:24]); end
			S_KB2: begin mul_a = AW'(sph_kda_pkg::K5); mul_b = BW'(prod_q[45:24]); end
			S_O0: begin mul_a = cfg.inv_smooth_cubed; mul_b = BW'(sum_q[39:16]); end
			S_O1: begin mul_a = cfg.inv_smooth_cubed; mul_b = BW'(sum_q[15:0]); end
			S_O2: begin mul_a = sum_q; mul_b = BW'(sph_kda_pkg::KN_HI); end
			S_O3: begin mul_a = sum_q; mul_b = BW'(sph_kda_pkg::KN_LO); end
			default: ;
		endcase
	end

	always_comb begin
		r2_tot = r2_q + R2W'(prod_q);
		in_range = r2_tot < (R2W'(cfg.smooth_len_sq) << COORD_FRAC_BITS);
		sq_try = sq_res_q + sq_bit_q;
		u_full = prod_q >> USH;
		u_clamped = (u_full > PW'(sph_kda_pkg::U_ONE)) ? sph_kda_pkg::U_ONE : u_full[16:0];
		w_term = prod_q[57:24];
		w = (state_q == S_KA3) ? sph_kda_pkg::K1 - w_term : w_term;
		sum_add = {1'b0, sum_q} + (SW + 1)'(w);
		sum_next = sum_add[SW] ? sph_kda_pkg::SUM_MAX : sum_add[SW-1:0];
		dens_sum = {1'b0, hi_q} + 65'(prod_q[55:16]);
		dens_sat = dens_sum[64] ? '1 : dens_sum[63:0];
		vol_sum = {1'b0, vh_q} + 60'(prod_q[55:16]);
		vol_shift = vol_sum[59:16];
		vol_sat = (|vol_shift[43:40]) ? sph_kda_pkg::SUM_MAX : vol_shift[39:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sum_q <= '0;
			out_valid_q <= 1'b0;
			density_q <= '0;
			norm_q <= '0;
		end else begin
			if (out_ch.ready && !emit) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_st.avail) begin
						if (head.first) begin
							sum_q <= '0;
						end
						state_q <= head.far ? S_FIN : S_SQ0;
					end
				end
				S_SQ0: state_q <= S_SQ1;
				S_SQ1: state_q <= S_SQ2;
				S_SQ2: state_q <= S_SQ3;
				S_SQ3: state_q <= in_range ? S_SQRT : S_FIN;
				S_SQRT: begin
					if (sq_cnt_q == CNTW'(SQ_STEPS - 1)) begin
						state_q <= S_USC;
					end
				end
				S_USC: state_q <= S_UCL;
				S_UCL: state_q <= S_K0;
				S_K0: state_q <= (u_q < sph_kda_pkg::U_HALF) ? S_KA1 : S_KB1;
				S_KA1: state_q <= S_KA2;
				S_KA2: state_q <= S_KA3;
				S_KB1: state_q <= S_KB2;
				S_KB2: state_q <= S_KB3;
				S_KA3, S_KB3: begin
					sum_q <= sum_next;
					state_q <= S_FIN;
				end
				S_FIN: state_q <= last_q ? S_O0 : S_IDLE;
				S_O0: state_q <= S_O1;
				S_O1: state_q <= S_O2;
				S_O2: state_q <= S_O3;
				S_O3: state_q <= S_O4;
				S_O4: state_q <= S_EMIT;
				S_EMIT: begin
					// hold until the output register is free
					if (emit) begin
						out_valid_q <= 1'b1;
						density_q <= dens_q;
						norm_q <= vol_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (pop) begin
			ax_q <= head.ax;
			ay_q <= head.ay;
			az_q <= head.az;
			last_q <= head.last;
		end
		case (state_q)
			S_SQ1: r2_q <= R2W'(prod_q);
			S_SQ2: r2_q <= r2_tot;
			S_SQ3: begin
				sq_n_q <= r2_tot[SQW-1:0];
				sq_res_q <= '0;
				sq_bit_q <= SQW'(1) << (SQW - 2);
				sq_cnt_q <= '0;
			end
			S_SQRT: begin
				if (sq_n_q >= sq_try) begin
					sq_n_q <= sq_n_q - sq_try;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
				sq_cnt_q <= sq_cnt_q + 1'b1;
			end
			S_UCL: begin
				u_q <= u_clamped;
				v_q <= sph_kda_pkg::U_ONE - u_clamped;
			end
			S_O1: hi_q <= prod_q[63:0];
			S_O2: dens_q <= dens_sat;
			S_O3: vh_q <= prod_q[58:0];
			S_O4: vol_q <= vol_sat;
			default: ;
		endcase
	end

endmodule

// ===== sv/sph_kernel_density_accum_core.sv =====
// SPH cubic-spline kernel density accumulator, top level.
// Channels: in_ch takes one centre/neighbour pair per transaction with first and
// last marks; out_ch returns density and normalised volume once per last mark;
// cfg_ch writes box_length, smooth_len_sq, inv_smooth, inv_smooth_cubed (index 0..3),
// always ready, to be used only while the block is idle.
// The front end registers each transaction and pushes it into a short queue, so
// in_ch takes one transaction per cycle until the queue is full.
// The back end works one neighbour at a time over its shared multiplier and the
// bit-pair square root (S = (33 + COORD_FRAC_BITS) / 2 steps, 24 by default):
//   far axis: straight to the finish state; outside the smoothing length: the
//   squares, then finish; inside: squares, S root steps, scaling, clamp, kernel
//   polynomial and sum; a last mark adds the output scaling and the emit state.
// Reset clears the kernel sum, the queue and the output register, and loads the
// registers with box 0xFFFFFFFF and 1.0 for the others. A stalled receiver holds
// the result in the output register; the next result then waits in the emit state.
// Depends on sph_kda_pkg, sph_kda_if, sph_kda_front, sph_kda_fifo, sph_kda_back.
module sph_kernel_density_accum_core #(
	parameter int COORD_FRAC_BITS = sph_kda_pkg::COORD_FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = sph_kda_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	sph_kda_in_if.sink     in_ch,
	sph_kda_out_if.source  out_ch,
	sph_kda_cfg_if.sink    cfg_ch
);

	sph_kda_pkg::cfg_t      cfg_q;
	sph_kda_pkg::q_status_t q_st;
	sph_kda_pkg::item_t     push_item, head;
	logic                   fe_push, be_pop, be_emit;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_length <= sph_kda_pkg::BOX_LENGTH_RST;
			cfg_q.smooth_len_sq <= sph_kda_pkg::SMOOTH_LEN_SQ_RST;
			cfg_q.inv_smooth <= sph_kda_pkg::INV_SMOOTH_RST;
			cfg_q.inv_smooth_cubed <= sph_kda_pkg::INV_SMOOTH_CUBED_RST;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				sph_kda_pkg::REG_BOX_LENGTH: cfg_q.box_length <= cfg_ch.data[31:0];
				sph_kda_pkg::REG_SMOOTH_LEN_SQ: cfg_q.smooth_len_sq <= cfg_ch.data[31:0];
				sph_kda_pkg::REG_INV_SMOOTH: cfg_q.inv_smooth <= cfg_ch.data[31:0];
				sph_kda_pkg::REG_INV_SMOOTH_CUBED: cfg_q.inv_smooth_cubed <= cfg_ch.data;
				default: ;
			endcase
		end
	end

	sph_kda_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.box_length (cfg_q.box_length),
		.q_st       (q_st),
		.push       (fe_push),
		.push_item  (push_item)
	);

	sph_kda_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fe_push),
		.push_item (push_item),
		.pop       (be_pop),
		.head      (head),
		.q_st      (q_st)
	);

	sph_kda_back #(
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.q_st   (q_st),
		.head   (head),
		.pop    (be_pop),
		.emit   (be_emit),
		.out_ch (out_ch)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		fe_push |-> q_st.room)
		else $error("front pushed into a full queue");

	a_pop_avail: assert property (@(posedge clk) disable iff (!arst_n)
		be_pop |-> q_st.avail)
		else $error("back end popped an empty queue");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(be_emit))
		else $error("result appeared without an emit step");

endmodule
